>>> rtl/cpcr_pkg.sv
// ----------------------------------------------------------------------------
// cpcr_pkg
// Shared widths, pipeline stage positions, register indexes and the side-band
// record for the circle pair collision resolver.
// ----------------------------------------------------------------------------
package cpcr_pkg;

  // fixed point format
  localparam int FracBits   = 24;
  localparam int PosW       = 26;
  localparam int RadW       = 24;
  localparam int RestW      = 17;
  localparam int MdsqW      = 32;
  localparam int CfgIdxW    = 1;
  localparam int CfgDataW   = 32;

  // derived arithmetic widths
  localparam int RsW        = RadW + 1;
  localparam int AbsW       = PosW;
  localparam int SqW        = 2 * AbsW;
  localparam int DsqW       = SqW + 1;
  localparam int RsqW       = 2 * RsW;
  localparam int FloorShift = 2 * FracBits - MdsqW;

  // square root unit
  localparam int RootW      = RsW;
  localparam int SqrtInW    = 2 * RootW;
  localparam int SqrtRemW   = SqrtInW + 2;

  // divider unit: quotient never exceeds a radius under the overlap condition
  localparam int DivQW      = RadW;
  localparam int DivDenW    = RsW;
  localparam int DivNumW    = 50;
  localparam int ScaleW     = RadW;

  // saturation bounds
  localparam logic [PosW-1:0] PosMax = {1'b0, {(PosW-1){1'b1}}};
  localparam logic [PosW-1:0] PosMin = {1'b1, {(PosW-1){1'b0}}};

  // register reset values
  localparam logic [RestW-1:0] RestReset = RestW'(52429);
  localparam logic [MdsqW-1:0] MdsqReset = MdsqW'(429497);

  // stage positions along the pipeline
  localparam int StIn    = 1;
  localparam int StSq    = 2;
  localparam int StDsq   = 3;
  localparam int StPen   = StDsq + RootW + 1;
  localparam int StProd  = StPen + 1;
  localparam int StScale = StProd + DivQW + 1;
  localparam int StMul   = StScale + 1;
  localparam int StOut   = StMul + DivQW + 1;

  typedef enum logic [CfgIdxW-1:0] {
    CfgRestitution = 1'b0,
    CfgMinDistSq   = 1'b1
  } cfg_idx_e;

  // data that rides alongside the arithmetic
  typedef struct packed {
    logic [PosW-1:0]  ax;
    logic [PosW-1:0]  ay;
    logic [PosW-1:0]  bx;
    logic [PosW-1:0]  by;
    logic [RadW-1:0]  ra;
    logic [RadW-1:0]  rb;
    logic [RsW-1:0]   rs;
    logic [AbsW-1:0]  adx;
    logic [AbsW-1:0]  ady;
    logic             sx;
    logic             sy;
    logic             hit;
    logic [RootW-1:0] span;
  } side_t;

endpackage

>>> rtl/cpcr_sqrt_pipe.sv
// ----------------------------------------------------------------------------
// cpcr_sqrt_pipe
// Integer square root, one result bit per register stage, fully pipelined.
// ----------------------------------------------------------------------------
module cpcr_sqrt_pipe (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic [cpcr_pkg::SqrtInW-1:0]     rad_i,
  output logic [cpcr_pkg::RootW-1:0]       root_o
);

  logic [cpcr_pkg::SqrtRemW-1:0] rem_q   [1:cpcr_pkg::RootW];
  logic [cpcr_pkg::RootW-1:0]    root_q  [1:cpcr_pkg::RootW];
  logic [cpcr_pkg::SqrtRemW-1:0] rem_in  [1:cpcr_pkg::RootW];
  logic [cpcr_pkg::RootW-1:0]    root_in [1:cpcr_pkg::RootW];

  // feed the first stage from the radicand
  assign rem_in[1]  = cpcr_pkg::SqrtRemW'(rad_i);
  assign root_in[1] = '0;

  for (genvar j = 2; j <= cpcr_pkg::RootW; j++) begin : g_link
    assign rem_in[j]  = rem_q[j-1];
    assign root_in[j] = root_q[j-1];
  end

  // each stage tries to set one root bit, most significant first
  for (genvar j = 1; j <= cpcr_pkg::RootW; j++) begin : g_stage
    localparam int Bit = cpcr_pkg::RootW - j;
    logic [cpcr_pkg::SqrtRemW-1:0] trial;

    assign trial = (cpcr_pkg::SqrtRemW'(root_in[j]) << (Bit + 1))
                 | (cpcr_pkg::SqrtRemW'(1) << (2 * Bit));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rem_in[j] >= trial) begin
          rem_q[j]  <= rem_in[j] - trial;
          root_q[j] <= root_in[j] | (cpcr_pkg::RootW'(1) << Bit);
        end else begin
          rem_q[j]  <= rem_in[j];
          root_q[j] <= root_in[j];
        end
      end
    end
  end

  assign root_o = root_q[cpcr_pkg::RootW];

endmodule

>>> rtl/cpcr_div_pipe.sv
// ----------------------------------------------------------------------------
// cpcr_div_pipe
// Restoring unsigned divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module cpcr_div_pipe (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic [cpcr_pkg::DivNumW-1:0]   num_i,
  input  logic [cpcr_pkg::DivDenW-1:0]   den_i,
  output logic [cpcr_pkg::DivQW-1:0]     quo_o
);

  logic [cpcr_pkg::DivNumW-1:0] rem_q  [1:cpcr_pkg::DivQW];
  logic [cpcr_pkg::DivDenW-1:0] den_q  [1:cpcr_pkg::DivQW];
  logic [cpcr_pkg::DivQW-1:0]   quo_q  [1:cpcr_pkg::DivQW];
  logic [cpcr_pkg::DivNumW-1:0] rem_in [1:cpcr_pkg::DivQW];
  logic [cpcr_pkg::DivDenW-1:0] den_in [1:cpcr_pkg::DivQW];
  logic [cpcr_pkg::DivQW-1:0]   quo_in [1:cpcr_pkg::DivQW];

  assign rem_in[1] = num_i;
  assign den_in[1] = den_i;
  assign quo_in[1] = '0;

  for (genvar j = 2; j <= cpcr_pkg::DivQW; j++) begin : g_link
    assign rem_in[j] = rem_q[j-1];
    assign den_in[j] = den_q[j-1];
    assign quo_in[j] = quo_q[j-1];
  end

  // subtract the shifted divisor where it fits, most significant bit first
  for (genvar j = 1; j <= cpcr_pkg::DivQW; j++) begin : g_stage
    localparam int Bit = cpcr_pkg::DivQW - j;
    logic [cpcr_pkg::DivNumW-1:0] trial;

    assign trial = cpcr_pkg::DivNumW'(den_in[j]) << Bit;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[j] <= den_in[j];
        if (rem_in[j] >= trial) begin
          rem_q[j] <= rem_in[j] - trial;
          quo_q[j] <= quo_in[j] | (cpcr_pkg::DivQW'(1) << Bit);
        end else begin
          rem_q[j] <= rem_in[j];
          quo_q[j] <= quo_in[j];
        end
      end
    end
  end

  assign quo_o = quo_q[cpcr_pkg::DivQW];

endmodule

>>> rtl/circle_pair_collision_resolve.sv
// ----------------------------------------------------------------------------
// circle_pair_collision_resolve
// Separates two overlapping circles along their normal, Q2.24 positions.
// ----------------------------------------------------------------------------
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  input    | in_valid_i/in_ready_o, a_*, b_* fields    | in
//  result   | out_valid_o/out_ready_i, new_*, collided  | out
//  config   | cfg_valid_i/cfg_ready_o, index, data      | in
//
//  One item enters per cycle while no result is held at the output; its
//  result passes the 25-stage square root and two rows of 24-stage
//  dividers across 81 register stages.
//  Reset clears the stage valid bits and loads the default registers.
//  A result held at the output stalls the whole pipeline in place, input
//  included; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module circle_pair_collision_resolve (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [cpcr_pkg::PosW-1:0]    a_pos_x_i,
  input  logic signed [cpcr_pkg::PosW-1:0]    a_pos_y_i,
  input  logic        [cpcr_pkg::RadW-1:0]    a_radius_i,
  input  logic signed [cpcr_pkg::PosW-1:0]    b_pos_x_i,
  input  logic signed [cpcr_pkg::PosW-1:0]    b_pos_y_i,
  input  logic        [cpcr_pkg::RadW-1:0]    b_radius_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [cpcr_pkg::PosW-1:0]    new_a_x_o,
  output logic signed [cpcr_pkg::PosW-1:0]    new_a_y_o,
  output logic signed [cpcr_pkg::PosW-1:0]    new_b_x_o,
  output logic signed [cpcr_pkg::PosW-1:0]    new_b_y_o,
  output logic                                collided_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [cpcr_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [cpcr_pkg::CfgDataW-1:0]       cfg_data_i
);

  localparam int PosW = cpcr_pkg::PosW;
  localparam int NumSt = cpcr_pkg::StOut;

  logic                            en;
  logic [NumSt:1]                  valid_q;
  cpcr_pkg::side_t                 side_q [1:NumSt-1];
  cpcr_pkg::side_t                 side_in;
  cpcr_pkg::side_t                 side_dsq;
  cpcr_pkg::side_t                 side_pen;

  logic [cpcr_pkg::RestW-1:0]      rest_q;
  logic [cpcr_pkg::MdsqW-1:0]      mdsq_q;

  logic [PosW:0]                   dx;
  logic [PosW:0]                   dy;
  logic [cpcr_pkg::SqW-1:0]        sqx_q, sqy_q;
  logic [cpcr_pkg::RsqW-1:0]       rsq_q;
  logic [cpcr_pkg::DsqW-1:0]       dsq_d, dsq_q, floor_sq;
  logic                            hit_d;
  logic [cpcr_pkg::RootW-1:0]      root;
  logic [cpcr_pkg::RsW-1:0]        pen_q;
  logic [cpcr_pkg::DivNumW-1:0]    pa_q, pb_q;
  logic [cpcr_pkg::DivQW-1:0]      ma, mb;
  logic [cpcr_pkg::ScaleW-1:0]     sa_q, sb_q;
  logic [cpcr_pkg::RestW+cpcr_pkg::ScaleW-1:0] sa_full, sb_full;
  logic [cpcr_pkg::DivNumW-1:0]    pax_q, pay_q, pbx_q, pby_q;
  logic [cpcr_pkg::DivQW-1:0]      push_ax, push_ay, push_bx, push_by;
  logic [PosW-1:0]                 nax_q, nay_q, nbx_q, nby_q;
  logic                            coll_q;

  // move one position by a signed push and clamp to the position range
  function automatic logic [PosW-1:0] shift_sat(logic [PosW-1:0] pos,
                                                 logic [cpcr_pkg::DivQW-1:0] mag,
                                                 logic neg);
    logic [PosW:0] ext;
    logic [PosW:0] sum;
    ext = (PosW+1)'(mag);
    sum = {pos[PosW-1], pos} + (neg ? (~ext + 1'b1) : ext);
    if (sum[PosW] != sum[PosW-1]) begin
      shift_sat = sum[PosW] ? cpcr_pkg::PosMin : cpcr_pkg::PosMax;
    end else begin
      shift_sat = sum[PosW-1:0];
    end
  endfunction

  // advance whenever the output stage is empty or being taken
  assign en          = !valid_q[NumSt] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = valid_q[NumSt];
  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rest_q <= cpcr_pkg::RestReset;
      mdsq_q <= cpcr_pkg::MdsqReset;
    end else if (cfg_valid_i) begin
      unique case (cpcr_pkg::cfg_idx_e'(cfg_index_i))
        cpcr_pkg::CfgRestitution: rest_q <= cfg_data_i[cpcr_pkg::RestW-1:0];
        cpcr_pkg::CfgMinDistSq:   mdsq_q <= cfg_data_i[cpcr_pkg::MdsqW-1:0];
        default: ;
      endcase
    end
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[NumSt-1:1], in_valid_i};
    end
  end

  // offsets, their magnitudes and the radius sum
  always_comb begin
    dx = {a_pos_x_i[PosW-1], a_pos_x_i} - {b_pos_x_i[PosW-1], b_pos_x_i};
    dy = {a_pos_y_i[PosW-1], a_pos_y_i} - {b_pos_y_i[PosW-1], b_pos_y_i};
    side_in      = '0;
    side_in.ax   = a_pos_x_i;
    side_in.ay   = a_pos_y_i;
    side_in.bx   = b_pos_x_i;
    side_in.by   = b_pos_y_i;
    side_in.ra   = a_radius_i;
    side_in.rb   = b_radius_i;
    side_in.rs   = cpcr_pkg::RsW'(a_radius_i) + cpcr_pkg::RsW'(b_radius_i);
    side_in.sx   = dx[PosW];
    side_in.sy   = dy[PosW];
    side_in.adx  = dx[PosW] ? cpcr_pkg::AbsW'(~dx + 1'b1) : dx[PosW-1:0];
    side_in.ady  = dy[PosW] ? cpcr_pkg::AbsW'(~dy + 1'b1) : dy[PosW-1:0];
  end

  // overlap test on the squared distance
  assign floor_sq = cpcr_pkg::DsqW'(mdsq_q) << cpcr_pkg::FloorShift;
  assign dsq_d    = cpcr_pkg::DsqW'(sqx_q) + cpcr_pkg::DsqW'(sqy_q);
  assign hit_d    = (dsq_d < cpcr_pkg::DsqW'(rsq_q)) && (dsq_d > floor_sq)
                 && (side_q[cpcr_pkg::StSq].rs != '0);

  // side-band records that pick up the overlap flag and the distance
  always_comb begin
    side_dsq      = side_q[cpcr_pkg::StSq];
    side_dsq.hit  = hit_d;
    side_pen      = side_q[cpcr_pkg::StPen-1];
    side_pen.span = root;
  end

  // scale the per-circle shares by restitution
  assign sa_full = ma * rest_q;
  assign sb_full = mb * rest_q;

  // datapath registers and the side-band shift line
  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[cpcr_pkg::StIn] <= side_in;
      for (int k = 2; k < NumSt; k++) begin
        if (k == cpcr_pkg::StDsq) begin
          side_q[k] <= side_dsq;
        end else if (k == cpcr_pkg::StPen) begin
          side_q[k] <= side_pen;
        end else begin
          side_q[k] <= side_q[k-1];
        end
      end

      sqx_q <= side_q[cpcr_pkg::StIn].adx * side_q[cpcr_pkg::StIn].adx;
      sqy_q <= side_q[cpcr_pkg::StIn].ady * side_q[cpcr_pkg::StIn].ady;
      rsq_q <= side_q[cpcr_pkg::StIn].rs * side_q[cpcr_pkg::StIn].rs;
      dsq_q <= dsq_d;

      pen_q <= side_q[cpcr_pkg::StPen-1].rs - root;
      pa_q  <= cpcr_pkg::DivNumW'(pen_q) * cpcr_pkg::DivNumW'(side_q[cpcr_pkg::StPen].ra);
      pb_q  <= cpcr_pkg::DivNumW'(pen_q) * cpcr_pkg::DivNumW'(side_q[cpcr_pkg::StPen].rb);

      sa_q  <= sa_full[cpcr_pkg::RestW +: cpcr_pkg::ScaleW];
      sb_q  <= sb_full[cpcr_pkg::RestW +: cpcr_pkg::ScaleW];

      pax_q <= cpcr_pkg::DivNumW'(side_q[cpcr_pkg::StScale].adx) * cpcr_pkg::DivNumW'(sb_q);
      pay_q <= cpcr_pkg::DivNumW'(side_q[cpcr_pkg::StScale].ady) * cpcr_pkg::DivNumW'(sb_q);
      pbx_q <= cpcr_pkg::DivNumW'(side_q[cpcr_pkg::StScale].adx) * cpcr_pkg::DivNumW'(sa_q);
      pby_q <= cpcr_pkg::DivNumW'(side_q[cpcr_pkg::StScale].ady) * cpcr_pkg::DivNumW'(sa_q);

      // output stage: apply pushes or pass positions through
      if (side_q[NumSt-1].hit) begin
        nax_q <= shift_sat(side_q[NumSt-1].ax, push_ax, side_q[NumSt-1].sx);
        nay_q <= shift_sat(side_q[NumSt-1].ay, push_ay, side_q[NumSt-1].sy);
        nbx_q <= shift_sat(side_q[NumSt-1].bx, push_bx, !side_q[NumSt-1].sx);
        nby_q <= shift_sat(side_q[NumSt-1].by, push_by, !side_q[NumSt-1].sy);
      end else begin
        nax_q <= side_q[NumSt-1].ax;
        nay_q <= side_q[NumSt-1].ay;
        nbx_q <= side_q[NumSt-1].bx;
        nby_q <= side_q[NumSt-1].by;
      end
      coll_q <= side_q[NumSt-1].hit;
    end
  end

  // distance from the squared distance
  cpcr_sqrt_pipe u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (dsq_q[cpcr_pkg::SqrtInW-1:0]),
    .root_o (root)
  );

  // penetration shares over the radius sum
  cpcr_div_pipe u_div_ma (
    .clk_i (clk_i), .en_i (en), .num_i (pa_q),
    .den_i (side_q[cpcr_pkg::StProd].rs), .quo_o (ma)
  );
  cpcr_div_pipe u_div_mb (
    .clk_i (clk_i), .en_i (en), .num_i (pb_q),
    .den_i (side_q[cpcr_pkg::StProd].rs), .quo_o (mb)
  );

  // push components along the normal
  cpcr_div_pipe u_div_ax (
    .clk_i (clk_i), .en_i (en), .num_i (pax_q),
    .den_i (side_q[cpcr_pkg::StMul].span), .quo_o (push_ax)
  );
  cpcr_div_pipe u_div_ay (
    .clk_i (clk_i), .en_i (en), .num_i (pay_q),
    .den_i (side_q[cpcr_pkg::StMul].span), .quo_o (push_ay)
  );
  cpcr_div_pipe u_div_bx (
    .clk_i (clk_i), .en_i (en), .num_i (pbx_q),
    .den_i (side_q[cpcr_pkg::StMul].span), .quo_o (push_bx)
  );
  cpcr_div_pipe u_div_by (
    .clk_i (clk_i), .en_i (en), .num_i (pby_q),
    .den_i (side_q[cpcr_pkg::StMul].span), .quo_o (push_by)
  );

  assign new_a_x_o  = nax_q;
  assign new_a_y_o  = nay_q;
  assign new_b_x_o  = nbx_q;
  assign new_b_y_o  = nby_q;
  assign collided_o = coll_q;

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the circle pair collision resolver. Circle pairs
// are streamed through a valid/ready driver, results are compared field by
// field against an in-bench integer predictor, under several register
// settings and idling phases.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int PosW       = cpcr_pkg::PosW;
  localparam int RadW       = cpcr_pkg::RadW;
  localparam int RestW      = cpcr_pkg::RestW;
  localparam int MdsqW      = cpcr_pkg::MdsqW;
  localparam int CfgIdxW    = cpcr_pkg::CfgIdxW;
  localparam int CfgDataW   = cpcr_pkg::CfgDataW;
  localparam int FloorShift = cpcr_pkg::FloorShift;

  localparam int Latency  = 81;
  localparam int DrainGap = 2 * Latency + 20;
  localparam int Watchdog = 20000;

  typedef struct {
    logic signed [PosW-1:0] ax, ay, bx, by;
    logic [RadW-1:0]        ra, rb;
  } pair_t;

  typedef struct {
    logic signed [PosW-1:0] nax, nay, nbx, nby;
    logic                   hit;
  } resolved_t;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  logic signed [PosW-1:0] a_x, a_y, b_x, b_y;
  logic [RadW-1:0] a_r, b_r;
  logic signed [PosW-1:0] o_ax, o_ay, o_bx, o_by;
  logic o_hit;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  pair_t     pending_pairs[$];
  resolved_t expected_pos[$];
  logic [RestW-1:0] rest_reg;
  logic [MdsqW-1:0] mdsq_reg;
  int  errors, idle_cycles, send_idle_pct, recv_stall_pct, hold_off;

  circle_pair_collision_resolve i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .a_pos_x_i(a_x), .a_pos_y_i(a_y), .a_radius_i(a_r),
    .b_pos_x_i(b_x), .b_pos_y_i(b_y), .b_radius_i(b_r),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .new_a_x_o(o_ax), .new_a_y_o(o_ay), .new_b_x_o(o_bx), .new_b_y_o(o_by),
    .collided_o(o_hit),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint axis_push(longint d, logic [63:0] s, logic [63:0] span);
    logic [63:0] m, p;
    m = (d < 0) ? -d : d;
    if (span == 0) return 0;
    p = (m * s) / span;
    return (d < 0) ? -longint'(p) : longint'(p);
  endfunction

  function automatic logic signed [PosW-1:0] clamp_pos(longint v);
    if (v > longint'(2**25 - 1)) return cpcr_pkg::PosMax;
    if (v < -longint'(2**25)) return cpcr_pkg::PosMin;
    return v[PosW-1:0];
  endfunction

  // Work out the separated positions of one pair
  function automatic resolved_t resolve_pair(pair_t p);
    resolved_t r;
    longint ax, ay, bx, by, dx, dy, nax, nay, nbx, nby;
    logic [63:0] dsq, rs, span, pen, ma, mb, sa, sb, fl;
    ax = p.ax; ay = p.ay; bx = p.bx; by = p.by;
    dx = ax - bx; dy = ay - by;
    dsq = 64'(dx * dx) + 64'(dy * dy);
    rs = 64'(p.ra) + 64'(p.rb);
    fl = 64'(mdsq_reg) << FloorShift;
    nax = ax; nay = ay; nbx = bx; nby = by;
    r.hit = 1'b0;
    if (dsq < rs * rs && dsq > fl && rs != 0) begin
      span = int_sqrt(dsq);
      pen = (rs > span) ? rs - span : 0;
      ma = (pen * p.ra) / rs;
      mb = (pen * p.rb) / rs;
      sa = (ma * rest_reg) >> 17;
      sb = (mb * rest_reg) >> 17;
      nax = ax + axis_push(dx, sb, span);
      nay = ay + axis_push(dy, sb, span);
      nbx = bx - axis_push(dx, sa, span);
      nby = by - axis_push(dy, sa, span);
      r.hit = 1'b1;
    end
    r.nax = clamp_pos(nax); r.nay = clamp_pos(nay);
    r.nbx = clamp_pos(nbx); r.nby = clamp_pos(nby);
    return r;
  endfunction

  function automatic pair_t mk_pair(longint ax, longint ay, longint ra,
                                    longint bx, longint by, longint rb);
    pair_t p;
    p.ax = ax[PosW-1:0]; p.ay = ay[PosW-1:0]; p.ra = ra[RadW-1:0];
    p.bx = bx[PosW-1:0]; p.by = by[PosW-1:0]; p.rb = rb[RadW-1:0];
    return p;
  endfunction

  // Queue one pair for the driver
  task automatic add_pair(pair_t p);
    pending_pairs.insert(pending_pairs.size(), p);
  endtask

  // Mostly overlapping pairs; some wide-range noise
  function automatic pair_t rand_pair();
    pair_t p;
    int sp;
    p.ra = RadW'($urandom); p.rb = RadW'($urandom);
    p.ax = PosW'($urandom); p.ay = PosW'($urandom);
    if ($urandom_range(0, 9) < 2) begin
      p.bx = PosW'($urandom); p.by = PosW'($urandom);
    end else begin
      sp = $urandom_range(0, 3);
      if (sp == 0) begin
        p.ra = RadW'($urandom_range(0, 65535));
        p.rb = RadW'($urandom_range(0, 65535));
      end
      p.bx = p.ax + $signed(PosW'($urandom_range(0, 2 * (p.ra + p.rb))))
           - (p.ra + p.rb);
      p.by = p.ay + $signed(PosW'($urandom_range(0, 2 * (p.ra + p.rb))))
           - (p.ra + p.rb);
    end
    return p;
  endfunction

  // Drive pending items; idle at the set rate
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      pair_t p;
      if (!in_valid || in_ready) begin
        if (pending_pairs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          p = pending_pairs.pop_front();
          expected_pos.insert(expected_pos.size(), resolve_pair(p));
          in_valid <= 1'b1;
          a_x <= p.ax; a_y <= p.ay; a_r <= p.ra;
          b_x <= p.bx; b_y <= p.by; b_r <= p.rb;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stalls, with a long hold-off when requested
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_off > 0) begin
      out_ready <= 1'b0;
      hold_off <= hold_off - 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Compare each result with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      resolved_t e;
      if (expected_pos.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %0d %0d %0d %0d %0b", $time,
                 o_ax, o_ay, o_bx, o_by, o_hit);
      end else begin
        e = expected_pos.pop_front();
        if (o_ax !== e.nax || o_ay !== e.nay || o_bx !== e.nbx ||
            o_by !== e.nby || o_hit !== e.hit) begin
          errors++;
          $display("%0t: mismatch exp %0d %0d %0d %0d %0b got %0d %0d %0d %0d %0b",
                   $time, e.nax, e.nay, e.nbx, e.nby, e.hit,
                   o_ax, o_ay, o_bx, o_by, o_hit);
        end
      end
    end
  end

  // Watchdog on cycles without any acceptance
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > Watchdog) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic write_reg(cpcr_pkg::cfg_idx_e idx, logic [CfgDataW-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1; cfg_idx <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == cpcr_pkg::CfgRestitution) rest_reg = val[RestW-1:0];
    else mdsq_reg = val;
  endtask

  task automatic drain();
    while (pending_pairs.size() != 0 || in_valid || expected_pos.size() != 0)
      @(posedge clk);
    repeat (DrainGap) @(posedge clk);
  endtask

  task automatic run_phase(int n, int si, int rs);
    send_idle_pct = si; recv_stall_pct = rs;
    repeat (n) add_pair(rand_pair());
    drain();
  endtask

  initial begin
    errors = 0; idle_cycles = 0; hold_off = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    rest_reg = cpcr_pkg::RestReset; mdsq_reg = cpcr_pkg::MdsqReset;
    cfg_valid = 1'b0; cfg_idx = '0; cfg_data = '0;
    a_x = '0; a_y = '0; a_r = '0; b_x = '0; b_y = '0; b_r = '0;
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, no overlap, too close, both radii zero, coincident
    add_pair(mk_pair(0, 0, 0, 0, 0, 0));
    add_pair(mk_pair(0, 0, 1 << 23, 0, 0, 1 << 23));
    add_pair(mk_pair(1, 0, 1 << 20, 0, 0, 1 << 20));
    add_pair(mk_pair(2**25 - 1, 2**25 - 1, 2**24 - 1,
                     2**25 - 100, 2**25 - 200, 2**24 - 1));
    add_pair(mk_pair(-2**25, -2**25, 2**24 - 1,
                     -2**25 + 77, -2**25 + 5, 2**24 - 1));
    add_pair(mk_pair(2**25 - 1, -2**25, 2**24 - 1,
                     -2**25, 2**25 - 1, 2**24 - 1));
    add_pair(mk_pair(1000, -3000, 1 << 22, -500, 2000, 0));
    add_pair(mk_pair(1 << 22, 0, 1 << 20, 0, 0, 1 << 20));
    add_pair(mk_pair(-400000, 300000, 1 << 21, 100000, -50000, 1 << 22));
    add_pair(mk_pair(30000, 40000, 100000, 0, 0, 100000));
    drain();

    // Register extremes, then phases with and without idling
    write_reg(cpcr_pkg::CfgRestitution, 65536);
    write_reg(cpcr_pkg::CfgMinDistSq, 0);
    add_pair(mk_pair(1, 1, 2**24 - 1, 0, 0, 2**24 - 1));
    run_phase(200, 0, 0);
    write_reg(cpcr_pkg::CfgRestitution, 0);
    write_reg(cpcr_pkg::CfgMinDistSq, 32'hFFFF_FFFF);
    run_phase(100, 67, 0);
    write_reg(cpcr_pkg::CfgRestitution, 2**RestW - 1);
    write_reg(cpcr_pkg::CfgMinDistSq, 32'd429497);
    run_phase(200, 0, 67);
    write_reg(cpcr_pkg::CfgRestitution, $urandom_range(0, 65536));
    write_reg(cpcr_pkg::CfgMinDistSq, $urandom_range(0, 1 << 20));
    run_phase(200, 29, 29);

    // Hold the receiver off long enough to back up the pipeline
    hold_off = 300;
    run_phase(150, 0, 0);
    write_reg(cpcr_pkg::CfgRestitution, cpcr_pkg::RestReset);
    write_reg(cpcr_pkg::CfgMinDistSq, cpcr_pkg::MdsqReset);
    run_phase(200, 29, 29);

    if (errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
